/* rtl/bptc_pkg.sv */
// ---------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ---------------------------------------------------------------------------
package bptc_pkg;

   // Configuration register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_C1 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_C2 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_C3 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_C4 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_C5 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_C6 = 3'd5;

   // Field widths
   localparam int RAW_W  = 24;
   localparam int TEMP_W = 19;
   localparam int PRES_W = 32;

   // Reference temperature, 20.00 degrees in hundredths
   localparam logic signed [TEMP_W:0]   TEMP_REF = 20'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};

   typedef struct packed {
      logic [CSR_DATA_W-1:0] c1;
      logic [CSR_DATA_W-1:0] c2;
      logic [CSR_DATA_W-1:0] c3;
      logic [CSR_DATA_W-1:0] c4;
      logic [CSR_DATA_W-1:0] c5;
      logic [CSR_DATA_W-1:0] c6;
   } calib_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_centi;
      logic signed [PRES_W-1:0] pressure_pa;
      logic                     low_temp_corrected;
   } result_type;

endpackage

/* rtl/bptc_datapath.sv */
// ---------------------------------------------------------------------------
// bptc_datapath
// Ten-stage compensation datapath; all stages advance together on adv.
// ---------------------------------------------------------------------------
module bptc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [23:0]            raw_temperature,
   input  logic [23:0]            raw_pressure,
   input  bptc_pkg::calib_type    calib,
   output logic                   out_valid,
   output bptc_pkg::result_type   out_result
);
   import bptc_pkg::*;

   logic [10:1] valid_ff;

   // Stage 1: temperature difference
   logic signed [24:0] s1_dt_in, s1_dt_ff;
   logic [23:0]        s1_press_ff;

   // Stage 2: first products
   logic signed [41:0] s2_pt_in, s2_pt_ff;
   logic signed [41:0] s2_po_in, s2_po_ff;
   logic signed [41:0] s2_ps_in, s2_ps_ff;
   logic [47:0]        s2_pdd_in, s2_pdd_ff;
   logic [23:0]        s2_press_ff;

   // Stage 3: first-order terms
   logic signed [18:0] s3_q_in, s3_q_ff;
   logic signed [39:0] s3_off_in, s3_off_ff;
   logic signed [39:0] s3_sens_in, s3_sens_ff;
   logic [16:0]        s3_t2_ff;
   logic               s3_low_ff;
   logic [23:0]        s3_press_ff;

   // Stage 4: square of the temperature deviation, final temperature
   logic signed [37:0]       s4_sq_in, s4_sq_ff;
   logic signed [TEMP_W:0]   s4_tsum;
   logic signed [TEMP_W-1:0] s4_temp_in, s4_temp_ff;
   logic signed [39:0]       s4_off_ff, s4_sens_ff;
   logic                     s4_low_ff;
   logic [23:0]              s4_press_ff;

   // Stage 5: five times the square
   logic signed [37:0]       s5_sq5_in, s5_sq5_ff;
   logic signed [39:0]       s5_off_ff, s5_sens_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff;
   logic                     s5_low_ff;
   logic [23:0]              s5_press_ff;

   // Stage 6: second-order offset and sensitivity
   logic signed [39:0]       s6_off_in, s6_off_ff;
   logic signed [39:0]       s6_sens_in, s6_sens_ff;
   logic signed [TEMP_W-1:0] s6_temp_ff;
   logic                     s6_low_ff;
   logic [23:0]              s6_press_ff;

   // Stage 7: split pressure product
   logic [43:0]              s7_plo_in, s7_plo_ff;
   logic signed [43:0]       s7_phi_in, s7_phi_ff;
   logic signed [39:0]       s7_off_ff;
   logic signed [TEMP_W-1:0] s7_temp_ff;
   logic                     s7_low_ff;

   // Stage 8: recombine, drop 21 fraction bits
   logic signed [63:0]       s8_x_in;
   logic signed [42:0]       s8_x_ff;
   logic signed [39:0]       s8_off_ff;
   logic signed [TEMP_W-1:0] s8_temp_ff;
   logic                     s8_low_ff;

   // Stage 9: subtract offset
   logic signed [43:0]       s9_y_in, s9_y_ff;
   logic signed [TEMP_W-1:0] s9_temp_ff;
   logic                     s9_low_ff;

   // Stage 10: divide by 2^15 toward zero
   logic signed [28:0]       s10_p_in, s10_p_ff;
   logic signed [TEMP_W-1:0] s10_temp_ff;
   logic                     s10_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[9:1], in_valid};
      end
   end

   assign s1_dt_in   = $signed({1'b0, raw_temperature}) - $signed({1'b0, calib.c5, 8'd0});

   assign s2_pt_in   = s1_dt_ff * $signed({1'b0, calib.c6});
   assign s2_po_in   = s1_dt_ff * $signed({1'b0, calib.c4});
   assign s2_ps_in   = s1_dt_ff * $signed({1'b0, calib.c3});
   assign s2_pdd_in  = s1_dt_ff * s1_dt_ff;

   // Truncate toward zero: bump the floor when negative with a nonzero remainder
   assign s3_q_in    = s2_pt_ff[41:23] + 19'(s2_pt_ff[41] & (|s2_pt_ff[22:0]));
   assign s3_off_in  = $signed({8'd0, calib.c2, 16'd0})
                     + $signed({{5{s2_po_ff[41]}}, s2_po_ff[41:7]});
   assign s3_sens_in = $signed({9'd0, calib.c1, 15'd0})
                     + $signed({{6{s2_ps_ff[41]}}, s2_ps_ff[41:8]});

   assign s4_sq_in   = s3_q_ff * s3_q_ff;
   assign s4_tsum    = $signed({s3_q_ff[18], s3_q_ff}) + TEMP_REF
                     - (s3_low_ff ? $signed({3'd0, s3_t2_ff}) : 20'sd0);

   always_comb begin
      if (s4_tsum[TEMP_W] != s4_tsum[TEMP_W-1]) begin
         s4_temp_in = s4_tsum[TEMP_W] ? TEMP_MIN : TEMP_MAX;
      end else begin
         s4_temp_in = s4_tsum[TEMP_W-1:0];
      end
   end

   assign s5_sq5_in  = s4_sq_ff + (s4_sq_ff <<< 2);

   assign s6_off_in  = s5_off_ff
                     - (s5_low_ff ? $signed({{3{s5_sq5_ff[37]}}, s5_sq5_ff[37:1]}) : 40'sd0);
   assign s6_sens_in = s5_sens_ff
                     - (s5_low_ff ? $signed({{4{s5_sq5_ff[37]}}, s5_sq5_ff[37:2]}) : 40'sd0);

   assign s7_plo_in  = s6_press_ff * s6_sens_ff[19:0];
   assign s7_phi_in  = $signed({1'b0, s6_press_ff}) * $signed(s6_sens_ff[39:20]);

   assign s8_x_in    = $signed({s7_phi_ff, 20'd0}) + $signed({20'd0, s7_plo_ff});

   assign s9_y_in    = $signed({s8_x_ff[42], s8_x_ff}) - $signed({{4{s8_off_ff[39]}}, s8_off_ff});

   assign s10_p_in   = s9_y_ff[43:15] + 29'(s9_y_ff[43] & (|s9_y_ff[14:0]));

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dt_ff    <= s1_dt_in;
         s1_press_ff <= raw_pressure;

         s2_pt_ff    <= s2_pt_in;
         s2_po_ff    <= s2_po_in;
         s2_ps_ff    <= s2_ps_in;
         s2_pdd_ff   <= s2_pdd_in;
         s2_press_ff <= s1_press_ff;

         s3_q_ff     <= s3_q_in;
         s3_low_ff   <= s3_q_in[18];
         s3_off_ff   <= s3_off_in;
         s3_sens_ff  <= s3_sens_in;
         s3_t2_ff    <= s2_pdd_ff[47:31];
         s3_press_ff <= s2_press_ff;

         s4_sq_ff    <= s4_sq_in;
         s4_temp_ff  <= s4_temp_in;
         s4_off_ff   <= s3_off_ff;
         s4_sens_ff  <= s3_sens_ff;
         s4_low_ff   <= s3_low_ff;
         s4_press_ff <= s3_press_ff;

         s5_sq5_ff   <= s5_sq5_in;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_temp_ff  <= s4_temp_ff;
         s5_low_ff   <= s4_low_ff;
         s5_press_ff <= s4_press_ff;

         s6_off_ff   <= s6_off_in;
         s6_sens_ff  <= s6_sens_in;
         s6_temp_ff  <= s5_temp_ff;
         s6_low_ff   <= s5_low_ff;
         s6_press_ff <= s5_press_ff;

         s7_plo_ff   <= s7_plo_in;
         s7_phi_ff   <= s7_phi_in;
         s7_off_ff   <= s6_off_ff;
         s7_temp_ff  <= s6_temp_ff;
         s7_low_ff   <= s6_low_ff;

         s8_x_ff     <= s8_x_in[63:21];
         s8_off_ff   <= s7_off_ff;
         s8_temp_ff  <= s7_temp_ff;
         s8_low_ff   <= s7_low_ff;

         s9_y_ff     <= s9_y_in;
         s9_temp_ff  <= s8_temp_ff;
         s9_low_ff   <= s8_low_ff;

         s10_p_ff    <= s10_p_in;
         s10_temp_ff <= s9_temp_ff;
         s10_low_ff  <= s9_low_ff;
      end
   end

   // The pressure quotient stays within 29 signed bits, so no clamp is needed
   assign out_valid                     = valid_ff[10];
   assign out_result.temperature_centi  = s10_temp_ff;
   assign out_result.pressure_pa        = {{(PRES_W-29){s10_p_ff[28]}}, s10_p_ff};
   assign out_result.low_temp_corrected = s10_low_ff;

endmodule

/* rtl/baro_pressure_temp_compensation.sv */
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order barometric temperature and pressure compensation, pipelined.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_ready  req_raw_temperature, req_raw_pressure
//   rsp      out  rsp_valid/rsp_ready  rsp_temperature_centi, rsp_pressure_pa,
//                                      rsp_low_temp_corrected
//   csr      in   csr_we               csr_index, csr_wdata
//
// One transaction enters per cycle while req_ready is high; a result passes the
// 10 datapath stages and then the output register before it reaches rsp.
// Latency is set by the dependent chain from the temperature difference through
// the square, the correction and the split pressure product, each stage holding
// one multiply or add step of the chain; only a full skid register stalls requests.
// Reset clears the valid bits, the output and skid flags and the calibration words.
// When rsp stalls, the pipeline keeps moving until one result sits in the
// skid register, then req_ready drops; no transaction is lost or repeated.
// ---------------------------------------------------------------------------
module baro_pressure_temp_compensation (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_raw_temperature,
   input  logic [23:0] req_raw_pressure,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [18:0] rsp_temperature_centi,
   output logic signed [31:0] rsp_pressure_pa,
   output logic        rsp_low_temp_corrected,

   input  logic        csr_we,
   input  logic [bptc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bptc_pkg::*;

   calib_type  calib_ff;

   logic       adv;
   logic       pipe_valid;
   result_type pipe_result;
   logic       arrive;

   logic       out_valid_ff;
   result_type out_result_ff;
   logic       skid_valid_ff;
   result_type skid_result_ff;

   // Calibration register file; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_CALIB_C1: calib_ff.c1 <= csr_wdata;
            REG_CALIB_C2: calib_ff.c2 <= csr_wdata;
            REG_CALIB_C3: calib_ff.c3 <= csr_wdata;
            REG_CALIB_C4: calib_ff.c4 <= csr_wdata;
            REG_CALIB_C5: calib_ff.c5 <= csr_wdata;
            REG_CALIB_C6: calib_ff.c6 <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance the whole pipeline unless the skid register is holding a result
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   bptc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (req_valid),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .calib           (calib_ff),
      .out_valid       (pipe_valid),
      .out_result      (pipe_result)
   );

   assign arrive = pipe_valid && adv;

   // Output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= arrive;
         end
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_result_ff <= skid_valid_ff ? skid_result_ff : pipe_result;
      end else if (arrive) begin
         skid_result_ff <= pipe_result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_temperature_centi  = out_result_ff.temperature_centi;
   assign rsp_pressure_pa        = out_result_ff.pressure_pa;
   assign rsp_low_temp_corrected = out_result_ff.low_temp_corrected;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometric compensation pipeline: directed and
// random conversion pairs under several calibration sets, with random gaps on
// the request side and random stalls on the response side, every result
// checked field by field against an in-bench second-order compensation model.
// ---------------------------------------------------------------------------
module tb_top;
   import bptc_pkg::*;

   // Scaling constants of the compensation formulas
   localparam longint T_SCALE     = 64'sd8388608;   // 2^23
   localparam longint P_SCALE     = 64'sd32768;     // 2^15
   localparam longint CORR_FACTOR = 64'sd5;
   localparam longint PRES_MAX    = 64'sd2147483647;
   localparam longint PRES_MIN    = -64'sd2147483648;

   // Register indexes beyond the calibration file; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_SETS  = 6;
   localparam int ITEMS_PER_SET = 100;
   localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

   // A plausible factory calibration set; reference point sits near 20 degrees
   localparam calib_type TYPICAL_CALIB = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                           c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
   localparam calib_type MAX_CALIB     = '{default: 16'hFFFF};

   typedef struct {
      logic [RAW_W-1:0] raw_temperature;
      logic [RAW_W-1:0] raw_pressure;
   } conversion_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [RAW_W-1:0] req_raw_temperature = '0;
   logic [RAW_W-1:0] req_raw_pressure = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temperature_centi;
   logic signed [PRES_W-1:0] rsp_pressure_pa;
   logic                     rsp_low_temp_corrected;

   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   conversion_pair_type pending_conversions[$];
   result_type          expected_results[$];
   calib_type           calib_shadow = '0;

   int cycle_count = 0;
   int mismatch_count = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   logic no_idle;

   baro_pressure_temp_compensation dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_raw_temperature    (req_raw_temperature),
      .req_raw_pressure       (req_raw_pressure),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_temperature_centi  (rsp_temperature_centi),
      .rsp_pressure_pa        (rsp_pressure_pa),
      .rsp_low_temp_corrected (rsp_low_temp_corrected),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Open a window with no idling on either side now and then, so back-to-back
   // traffic and a full pipeline are exercised as well as sparse traffic.
   assign no_idle = (cycle_count % 1500) < 250;

   function automatic int draw_wait();
      if (no_idle)
         return 0;
      return $urandom_range(0, 13);
   endfunction

   // Second-order compensation of one conversion pair. All intermediates fit in
   // 64 bits: the widest product is a 24-bit raw pressure times a ~36-bit SENS.
   // Division truncates toward zero; >>> on a signed value rounds toward minus
   // infinity, matching the floor terms of the datasheet formulas.
   function automatic result_type compensate(input logic [RAW_W-1:0] raw_t,
                                             input logic [RAW_W-1:0] raw_p,
                                             input calib_type cal);
      longint d_t, temp, offset, sens, pres, d_ref, d_sq;
      result_type r;
      d_t    = longint'(raw_t) - (longint'(cal.c5) << 8);
      temp   = longint'(TEMP_REF) + (d_t * longint'(cal.c6)) / T_SCALE;
      offset = (longint'(cal.c2) << 16) + ((longint'(cal.c4) * d_t) >>> 7);
      sens   = (longint'(cal.c1) << 15) + ((longint'(cal.c3) * d_t) >>> 8);
      r.low_temp_corrected = (temp < longint'(TEMP_REF));
      if (r.low_temp_corrected) begin
         // take the distance from 20 degrees before TEMP itself is corrected
         d_ref  = temp - longint'(TEMP_REF);
         d_sq   = d_ref * d_ref;
         offset = offset - ((CORR_FACTOR * d_sq) >>> 1);
         sens   = sens - ((CORR_FACTOR * d_sq) >>> 2);
         temp   = temp - ((d_t * d_t) >>> 31);
      end
      pres = (((longint'(raw_p) * sens) >>> 21) - offset) / P_SCALE;
      if (temp < longint'(TEMP_MIN))
         temp = longint'(TEMP_MIN);
      else if (temp > longint'(TEMP_MAX))
         temp = longint'(TEMP_MAX);
      if (pres < PRES_MIN)
         pres = PRES_MIN;
      else if (pres > PRES_MAX)
         pres = PRES_MAX;
      r.temperature_centi = temp[TEMP_W-1:0];
      r.pressure_pa       = pres[PRES_W-1:0];
      return r;
   endfunction

   function automatic void queue_conversion(input logic [RAW_W-1:0] raw_t,
                                            input logic [RAW_W-1:0] raw_p);
      conversion_pair_type conv;
      conv.raw_temperature = raw_t;
      conv.raw_pressure    = raw_p;
      pending_conversions.push_back(conv);
   endfunction

   // Favor the corner words, since they drive the widest intermediates
   function automatic logic [CSR_DATA_W-1:0] draw_calib_word();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return CSR_DATA_W'($urandom());
      endcase
   endfunction

   // Write one register and mirror it in the shadow copy; drop unknown indexes.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         REG_CALIB_C1: calib_shadow.c1 = data;
         REG_CALIB_C2: calib_shadow.c2 = data;
         REG_CALIB_C3: calib_shadow.c3 = data;
         REG_CALIB_C4: calib_shadow.c4 = data;
         REG_CALIB_C5: calib_shadow.c5 = data;
         REG_CALIB_C6: calib_shadow.c6 = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_calibration(input calib_type cal);
      write_csr(REG_CALIB_C1, cal.c1);
      write_csr(REG_CALIB_C2, cal.c2);
      write_csr(REG_CALIB_C3, cal.c3);
      write_csr(REG_CALIB_C4, cal.c4);
      write_csr(REG_CALIB_C5, cal.c5);
      write_csr(REG_CALIB_C6, cal.c6);
   endtask

   // Hold until every queued pair is accepted and every result has come back,
   // so the calibration can be changed with nothing in flight. Sample on the
   // falling edge, once the driver and monitor have settled.
   task automatic wait_pipeline_empty();
      @(negedge clock);
      while (pending_conversions.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: directed corners first, then random sets under fresh calibration
   // ------------------------------------------------------------------------
   initial begin : stimulus
      calib_type cal;
      logic [RAW_W-1:0] raw_t, raw_p;
      int ref_point, t_val;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Uncalibrated part: all-zero words, TEMP pinned at 20.00 degrees
      queue_conversion('0, '0);
      queue_conversion(RAW_MAX, RAW_MAX);
      queue_conversion('0, RAW_MAX);
      queue_conversion(RAW_MAX, '0);
      wait_pipeline_empty();

      // Typical part; spare register writes must leave the calibration alone
      load_calibration(TYPICAL_CALIB);
      write_csr(REG_SPARE_6, 16'hFFFF);
      write_csr(REG_SPARE_7, 16'h0000);
      ref_point = int'(TYPICAL_CALIB.c5) << 8;
      queue_conversion(RAW_W'(ref_point), 24'd9085466);
      // dT just above and just below the truncation step to 19.99 degrees
      queue_conversion(RAW_W'(ref_point - 296), 24'd9085466);
      queue_conversion(RAW_W'(ref_point - 297), 24'd9085466);
      queue_conversion(RAW_W'(ref_point + 1000), 24'h800000);
      queue_conversion('0, RAW_MAX);
      queue_conversion('0, '0);
      queue_conversion(RAW_MAX, RAW_MAX);
      queue_conversion(RAW_MAX, '0);
      wait_pipeline_empty();

      // All words at full scale: deepest cold correction and widest products
      load_calibration(MAX_CALIB);
      ref_point = int'(MAX_CALIB.c5) << 8;
      queue_conversion('0, RAW_MAX);
      queue_conversion('0, '0);
      queue_conversion(RAW_MAX, RAW_MAX);
      queue_conversion(RAW_W'(ref_point), RAW_MAX);
      queue_conversion(RAW_W'(ref_point - 1), RAW_MAX);
      queue_conversion(RAW_W'(ref_point - 1), '0);
      wait_pipeline_empty();

      for (int set = 0; set < RANDOM_SETS; set++) begin
         cal = '{c1: draw_calib_word(), c2: draw_calib_word(), c3: draw_calib_word(),
                 c4: draw_calib_word(), c5: draw_calib_word(), c6: draw_calib_word()};
         load_calibration(cal);
         ref_point = int'(cal.c5) << 8;
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            // Mix full-range temperatures with ones near and below the reference
            // point, so both branches and the 20-degree boundary see traffic.
            case ($urandom_range(0, 2))
               0: t_val = $urandom_range(0, int'(RAW_MAX));
               1: t_val = ref_point + $urandom_range(0, 8192) - 4096;
               default: t_val = ref_point - $urandom_range(0, 1 << 20);
            endcase
            if (t_val < 0)
               t_val = 0;
            else if (t_val > int'(RAW_MAX))
               t_val = int'(RAW_MAX);
            raw_t = RAW_W'(t_val);
            case ($urandom_range(0, 15))
               0: raw_p = '0;
               1: raw_p = RAW_MAX;
               default: raw_p = RAW_W'($urandom());
            endcase
            queue_conversion(raw_t, raw_p);
         end
         wait_pipeline_empty();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("baro_pressure_temp_compensation test passed");
      else
         $display("baro_pressure_temp_compensation test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: present one pair per transaction, then idle for a drawn
   // number of cycles. Record the expected result at acceptance time, when
   // the shadow calibration matches what the pipeline uses.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      conversion_pair_type conv;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(
               compensate(req_raw_temperature, req_raw_pressure, calib_shadow));
         // Advance only when the slot is free; otherwise hold valid and payload
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_conversions.size() != 0) begin
               conv = pending_conversions.pop_front();
               req_raw_temperature <= conv.raw_temperature;
               req_raw_pressure    <= conv.raw_pressure;
               req_valid           <= 1'b1;
               req_gap             <= draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: check every accepted transaction against the oldest
   // expectation, then drop ready for a drawn number of cycles.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      result_type want;
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got temp %0d pres %0d low %0b",
                     $time, rsp_temperature_centi, rsp_pressure_pa, rsp_low_temp_corrected);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_temperature_centi !== want.temperature_centi) begin
               $display("%0t: temperature_centi expected %0d, actual %0d",
                        $time, want.temperature_centi, rsp_temperature_centi);
               mismatch_count++;
            end
            if (rsp_pressure_pa !== want.pressure_pa) begin
               $display("%0t: pressure_pa expected %0d, actual %0d",
                        $time, want.pressure_pa, rsp_pressure_pa);
               mismatch_count++;
            end
            if (rsp_low_temp_corrected !== want.low_temp_corrected) begin
               $display("%0t: low_temp_corrected expected %0b, actual %0b",
                        $time, want.low_temp_corrected, rsp_low_temp_corrected);
               mismatch_count++;
            end
         end
         stall = draw_wait();
         rsp_stall <= stall;
         rsp_ready <= (stall == 0);
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Bound the run; a lost or stuck transaction ends up here
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("baro_pressure_temp_compensation test failed");
         $finish;
      end
   end

endmodule
